### src/clms_pkg.sv
// clms_pkg: shared widths and constants of the community move selector
// no dependencies
`default_nettype none
package clms_pkg;
    localparam int COMM_W = 32;
    localparam int DEG_W  = 31;
    localparam int GAIN_W = 55;
    localparam logic [COMM_W-1:0] EMPTY_COMMUNITY = 32'hFFFF_FFFF;
    localparam logic [63:0] GAIN_MAX = (64'd1 << GAIN_W) - 64'd1;
    typedef logic [COMM_W-1:0] t_comm;
    typedef logic [DEG_W-1:0]  t_deg;
    typedef logic [GAIN_W-1:0] t_gain;
endpackage
`default_nettype wire

### src/community_local_move_select.sv
// community_local_move_select: top level, tally sequencer and gain scan
// uses clms_pkg and clms_ram
//
// A neighbor word is accepted when start is high and busy is low. Its
// community is searched in the bucket memory one entry at a time, each entry
// read and then compared, as the memory has a single read port. On the last
// neighbor the gain scan passes every filled bucket through its read, multiply
// and compare states. The result word is shown for one cycle with o_valid and
// cannot be stalled; buckets empty at once after the decision.
`default_nettype none
module community_local_move_select #(
    parameter int BUCKETS         = 64,
    parameter int MAX_DEGREE_BITS = 24
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [2:0]               paddr,
    input  wire logic [31:0]              pwdata,
    output logic      [31:0]              prdata,
    output logic                          pready,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [clms_pkg::COMM_W-1:0] i_current_community,
    input  wire logic [clms_pkg::COMM_W-1:0] i_neighbor_community,
    input  wire logic [clms_pkg::DEG_W-1:0]  i_community_degree,
    input  wire logic                     i_last_neighbor,
    output logic                          o_valid,
    output logic [clms_pkg::COMM_W-1:0]   o_chosen_community,
    output logic                          o_moved,
    output logic [clms_pkg::GAIN_W-1:0]   o_best_gain
);
    import clms_pkg::*;

    localparam int CW = MAX_DEGREE_BITS;
    localparam int IW = $clog2(BUCKETS > 1 ? BUCKETS : 2);
    localparam int FW = $clog2(BUCKETS + 1);
    localparam int GW = CW + DEG_W;
    localparam int MW = COMM_W + CW + DEG_W;

    localparam logic [2:0] ADDR_TWO_M = 3'd0;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_T_RD  = 3'd1;
    localparam logic [2:0] S_T_CMP = 3'd2;
    localparam logic [2:0] S_G_RD  = 3'd3;
    localparam logic [2:0] S_G_MUL = 3'd4;
    localparam logic [2:0] S_G_CMP = 3'd5;

    logic [2:0]     r_state;
    logic [DEG_W-1:0] r_two_m;
    logic [FW-1:0]  r_fill;
    logic [FW-1:0]  r_idx;
    logic [CW-1:0]  r_total;
    t_comm          r_cur, r_comm, r_tag;
    t_deg           r_deg;
    logic           r_last;
    logic [GW-1:0]  r_plus, r_minus, r_best;
    t_comm          r_best_comm;

    logic           we;
    logic [IW-1:0]  waddr;
    logic [MW-1:0]  wdata, rdata;
    t_comm          rd_tag;
    logic [CW-1:0]  rd_cnt;
    t_deg           rd_deg;
    logic           cfg_wr;
    logic           take;
    logic [GW-1:0]  diff;
    logic           better;
    logic [GW-1:0]  fin_best;
    t_comm          fin_comm;
    logic [63:0]    fin_wide;

    assign {rd_tag, rd_cnt, rd_deg} = rdata;

    clms_ram #(.CNT_W(CW), .DEPTH(BUCKETS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (rdata)
    );

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TWO_M) ? {1'b0, r_two_m} : 32'd0;
    assign cfg_wr = psel && penable && pwrite;
    assign busy   = (r_state != S_IDLE);
    assign take   = start && !busy;

    assign diff   = r_plus - r_minus;
    assign better = (r_plus > r_minus) && (diff > r_best) && (r_tag != r_cur);

    always_comb begin
        fin_best = better ? diff : r_best;
        fin_comm = better ? r_tag : r_best_comm;
        fin_wide = 64'(fin_best);
        if (fin_wide > GAIN_MAX) begin
            fin_wide = GAIN_MAX;
        end
    end

    // memory writes: insert on accept into empty store, or update/insert after search
    always_comb begin
        we    = 1'b0;
        waddr = r_idx[IW-1:0];
        wdata = {rd_tag, rd_cnt, rd_deg};
        if (take && i_neighbor_community != EMPTY_COMMUNITY && r_fill == '0) begin
            we    = 1'b1;
            waddr = '0;
            wdata = {i_neighbor_community, CW'(1), i_community_degree};
        end else if (r_state == S_T_CMP) begin
            if (rd_tag == r_comm) begin
                we    = 1'b1;
                wdata = {rd_tag, (&rd_cnt) ? rd_cnt : rd_cnt + CW'(1), rd_deg};
            end else if (r_idx + FW'(1) == r_fill && r_fill < FW'(BUCKETS)) begin
                we    = 1'b1;
                waddr = r_fill[IW-1:0];
                wdata = {r_comm, CW'(1), r_deg};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_two_m <= '0;
            r_fill  <= '0;
            r_idx   <= '0;
            r_total <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (cfg_wr && paddr == ADDR_TWO_M) begin
                r_two_m <= pwdata[DEG_W-1:0];
            end
            case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_cur  <= i_current_community;
                        r_comm <= i_neighbor_community;
                        r_deg  <= i_community_degree;
                        r_last <= i_last_neighbor;
                        r_idx  <= '0;
                        r_best <= '0;
                        r_best_comm <= i_current_community;
                        if (!(&r_total)) begin
                            r_total <= r_total + CW'(1);
                        end
                        if (i_neighbor_community == EMPTY_COMMUNITY || r_fill == '0) begin
                            if (i_neighbor_community != EMPTY_COMMUNITY) begin
                                r_fill <= FW'(1);
                                r_state <= i_last_neighbor ? S_G_RD : S_IDLE;
                            end else if (i_last_neighbor) begin
                                if (r_fill == '0) begin
                                    o_valid <= 1'b1;
                                    o_chosen_community <= i_current_community;
                                    o_moved <= 1'b0;
                                    o_best_gain <= '0;
                                    r_total <= '0;
                                end else begin
                                    r_state <= S_G_RD;
                                end
                            end
                        end else begin
                            r_state <= S_T_RD;
                        end
                    end
                end
                S_T_RD: r_state <= S_T_CMP;
                S_T_CMP: begin
                    if (rd_tag == r_comm || r_idx + FW'(1) == r_fill) begin
                        if (rd_tag != r_comm && r_fill < FW'(BUCKETS)) begin
                            r_fill <= r_fill + FW'(1);
                        end
                        r_idx   <= '0;
                        r_state <= r_last ? S_G_RD : S_IDLE;
                    end else begin
                        r_idx   <= r_idx + FW'(1);
                        r_state <= S_T_RD;
                    end
                end
                S_G_RD: r_state <= S_G_MUL;
                S_G_MUL: begin
                    r_plus  <= GW'(rd_cnt) * GW'(r_two_m);
                    r_minus <= GW'(r_total) * GW'(rd_deg);
                    r_tag   <= rd_tag;
                    r_state <= S_G_CMP;
                end
                S_G_CMP: begin
                    r_best      <= fin_best;
                    r_best_comm <= fin_comm;
                    if (r_idx + FW'(1) == r_fill) begin
                        o_valid <= 1'b1;
                        o_chosen_community <= (fin_best == '0) ? r_cur : fin_comm;
                        o_moved <= (fin_best != '0);
                        o_best_gain <= GAIN_W'(fin_wide);
                        r_fill  <= '0;
                        r_total <= '0;
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + FW'(1);
                        r_state <= S_G_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### src/clms_ram.sv
// clms_ram: bucket store, one write port and one registered read port
// uses clms_pkg for the tag and degree widths
`default_nettype none
module clms_ram #(
    parameter int CNT_W = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [clms_pkg::COMM_W+CNT_W+clms_pkg::DEG_W-1:0] i_wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [clms_pkg::COMM_W+CNT_W+clms_pkg::DEG_W-1:0] o_rdata
);
    import clms_pkg::*;
    localparam int W = COMM_W + CNT_W + DEG_W;

    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
